/* sv/mbr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbr_pkg
// Shared types, constants and the hex decoder for the Modbus ASCII receiver.
// ---------------------------------------------------------------------------
package mbr_pkg;

    localparam int unsigned MIN_FRAME_CHARS = 9;
    localparam int unsigned MAX_FRAME_CHARS = 513;

    localparam int unsigned POS_W   = 10;
    localparam int unsigned LEN_W   = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] ADDR_BROADCAST = 8'd0;
    localparam logic [7:0] ADDR_DEFAULT   = 8'd248;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    localparam logic [7:0] RST_OWN_ADDRESS   = 8'd1;
    localparam logic [7:0] RST_END_DELIMITER = 8'd10;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_OWN_ADDRESS   = 2'd0,
        REG_END_DELIMITER = 2'd1,
        REG_DEFAULT_REPLY = 2'd2,
        REG_LISTEN_ONLY   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_BROADCAST = 3'd1,
        VERDICT_LENGTH    = 3'd2,
        VERDICT_FRAMING   = 3'd3,
        VERDICT_NON_HEX   = 3'd4,
        VERDICT_LRC       = 3'd5,
        VERDICT_OTHER     = 3'd6
    } t_verdict;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        t_verdict    verdict;
        logic        event_valid;
        logic        event_listen;
        logic        event_comm_error;
        logic        event_broadcast;
        logic [15:0] message_count;
        logic [15:0] error_count;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    // non-hex characters decode as nibble zero with ok cleared
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h = '{ok: 1'b1, nib: 4'd0};
        if (c inside {[8'h30:8'h39]}) begin
            h.nib = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h.nib = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* sv/mbr_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbr_char_if / mbr_result_if
// Valid/ready channels: received characters in, decoded words out.
// ---------------------------------------------------------------------------
interface mbr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;
    logic       frame_end;

    modport source (output valid, output rx_char, output frame_end, input ready);
    modport sink   (input valid, input rx_char, input frame_end, output ready);
endinterface

interface mbr_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [2:0]  verdict;
    logic        event_valid;
    logic        event_listen;
    logic        event_comm_error;
    logic        event_broadcast;
    logic [15:0] message_count;
    logic [15:0] error_count;

    modport source (output valid, output result_kind, output data_byte, output verdict,
                    output event_valid, output event_listen, output event_comm_error,
                    output event_broadcast, output message_count, output error_count,
                    input ready);
    modport sink   (input valid, input result_kind, input data_byte, input verdict,
                    input event_valid, input event_listen, input event_comm_error,
                    input event_broadcast, input message_count, input error_count,
                    output ready);
endinterface

/* sv/modbus_ascii_frame_receiver_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modbus_ascii_frame_receiver_top
// Modbus ASCII deframer: LRC check, address filter, data bytes and verdict.
// ---------------------------------------------------------------------------
// Throughput: one character per cycle while the output queue is not full; the
//   per-character update is one pass of logic from the frame state registers
//   into a two-entry output queue, which keeps taking characters while one
//   result word waits downstream.
// Reset (i_rst_n low, synchronous): registers to defaults, counters and frame
//   state cleared, output queue emptied.
// ---------------------------------------------------------------------------
module modbus_ascii_frame_receiver_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mbr_char_if.sink            i_rx,
    mbr_result_if.source        o_res,
    input  logic                i_cfg_we,
    input  mbr_pkg::t_reg_idx   i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);
    import mbr_pkg::*;

    // configuration
    logic [7:0] r_own_address;
    logic [7:0] r_end_delimiter;
    logic       r_default_reply;
    logic       r_listen_only;

    // per-frame state
    logic [POS_W-1:0] r_pos,        n_pos;
    logic             r_start_ok,   n_start_ok;
    logic [7:0]       r_dly0,       n_dly0;     // newest character
    logic [7:0]       r_dly1,       n_dly1;     // the one before
    logic             r_hex_ok,     n_hex_ok;
    logic [3:0]       r_high_nib,   n_high_nib;
    logic             r_phase,      n_phase;
    logic [7:0]       r_held,       n_held;
    logic             r_held_valid, n_held_valid;
    logic [7:0]       r_addr,       n_addr;
    logic [7:0]       r_sum,        n_sum;

    // running counters
    logic [15:0] r_msg_cnt, n_msg_cnt;
    logic [15:0] r_err_cnt, n_err_cnt;

    // output queue
    t_result    r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count,  n_count;

    logic       acc, push, pop, res_valid;
    t_result    res;
    t_hex       hx;
    logic [7:0] byte_new;
    logic [LEN_W-1:0] len;
    logic       len_bad, frame_bad;

    assign i_rx.ready = (r_count != 2'd2);
    assign acc  = i_rx.valid && i_rx.ready;
    assign pop  = o_res.valid && o_res.ready;
    assign push = acc && res_valid;

    assign hx       = hex_decode(r_dly1);
    assign byte_new = {r_high_nib, hx.nib};
    assign len      = {1'b0, r_pos} + LEN_W'(1);
    assign len_bad  = (len < LEN_W'(MIN_FRAME_CHARS)) || (len > LEN_W'(MAX_FRAME_CHARS));

    always_comb begin
        n_pos        = r_pos;
        n_start_ok   = r_start_ok;
        n_dly0       = r_dly0;
        n_dly1       = r_dly1;
        n_hex_ok     = r_hex_ok;
        n_high_nib   = r_high_nib;
        n_phase      = r_phase;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_addr       = r_addr;
        n_sum        = r_sum;
        n_msg_cnt    = r_msg_cnt;
        n_err_cnt    = r_err_cnt;
        res          = '0;
        res.verdict  = VERDICT_OK;
        res_valid    = 1'b0;
        frame_bad    = 1'b0;

        if (r_pos == '0) begin
            n_start_ok = (i_rx.rx_char == CHAR_COLON);
        end

        // body character is the one two positions back
        if (r_pos >= POS_W'(3)) begin
            n_hex_ok = r_hex_ok && hx.ok;
            if (!r_phase) begin
                n_high_nib = hx.nib;
                n_phase    = 1'b1;
                if (r_held_valid && !i_rx.frame_end && n_start_ok && n_hex_ok) begin
                    res.data_byte = r_held;
                    res_valid     = 1'b1;
                end
                n_held_valid = 1'b0;
            end else begin
                n_sum = r_sum + byte_new;
                if (r_pos == POS_W'(4)) begin
                    n_addr = byte_new;
                end
                n_held       = byte_new;
                n_held_valid = 1'b1;
                n_phase      = 1'b0;
            end
        end

        if (i_rx.frame_end) begin
            res           = '0;
            res_valid     = 1'b1;
            res.result_kind = 1'b1;
            if (len_bad) begin
                res.verdict = VERDICT_LENGTH;
            end else begin
                n_msg_cnt        = r_msg_cnt + 16'd1;
                res.event_listen = r_listen_only;
                frame_bad = !n_start_ok || (r_dly0 != CHAR_CR)
                         || (i_rx.rx_char != r_end_delimiter) || !len[0];
                if (frame_bad) begin
                    res.verdict = VERDICT_FRAMING;
                end else if (!n_hex_ok) begin
                    res.verdict = VERDICT_NON_HEX;
                end else if (n_sum != 8'd0) begin
                    res.verdict          = VERDICT_LRC;
                    n_err_cnt            = r_err_cnt + 16'd1;
                    res.event_comm_error = 1'b1;
                end else if (n_addr != r_own_address && n_addr != ADDR_BROADCAST
                             && !(r_default_reply && n_addr == ADDR_DEFAULT)) begin
                    res.verdict = VERDICT_OTHER;
                end else if (n_addr == ADDR_BROADCAST) begin
                    res.verdict         = VERDICT_BROADCAST;
                    res.event_broadcast = 1'b1;
                end else begin
                    res.verdict = VERDICT_OK;
                end
                res.event_valid = res.event_listen || res.event_comm_error
                               || res.event_broadcast;
            end
            res.message_count = n_msg_cnt;
            res.error_count   = n_err_cnt;

            // back to the idle frame state
            n_pos        = '0;
            n_start_ok   = 1'b0;
            n_dly0       = 8'd0;
            n_dly1       = 8'd0;
            n_hex_ok     = 1'b1;
            n_high_nib   = 4'd0;
            n_phase      = 1'b0;
            n_held       = 8'd0;
            n_held_valid = 1'b0;
            n_addr       = 8'd0;
            n_sum        = 8'd0;
        end else begin
            n_dly1 = r_dly0;
            n_dly0 = i_rx.rx_char;
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    assign n_count = r_count + 2'(push) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address   <= RST_OWN_ADDRESS;
            r_end_delimiter <= RST_END_DELIMITER;
            r_default_reply <= 1'b0;
            r_listen_only   <= 1'b0;
            r_pos        <= '0;
            r_start_ok   <= 1'b0;
            r_dly0       <= 8'd0;
            r_dly1       <= 8'd0;
            r_hex_ok     <= 1'b1;
            r_high_nib   <= 4'd0;
            r_phase      <= 1'b0;
            r_held       <= 8'd0;
            r_held_valid <= 1'b0;
            r_addr       <= 8'd0;
            r_sum        <= 8'd0;
            r_msg_cnt    <= 16'd0;
            r_err_cnt    <= 16'd0;
            r_wr_ptr     <= 1'b0;
            r_rd_ptr     <= 1'b0;
            r_count      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OWN_ADDRESS:   r_own_address   <= i_cfg_data;
                    REG_END_DELIMITER: r_end_delimiter <= i_cfg_data;
                    REG_DEFAULT_REPLY: r_default_reply <= i_cfg_data[0];
                    REG_LISTEN_ONLY:   r_listen_only   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (acc) begin
                r_pos        <= n_pos;
                r_start_ok   <= n_start_ok;
                r_dly0       <= n_dly0;
                r_dly1       <= n_dly1;
                r_hex_ok     <= n_hex_ok;
                r_high_nib   <= n_high_nib;
                r_phase      <= n_phase;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_addr       <= n_addr;
                r_sum        <= n_sum;
                r_msg_cnt    <= n_msg_cnt;
                r_err_cnt    <= n_err_cnt;
            end
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= n_count;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= res;
        end
    end

    assign o_res.valid            = (r_count != 2'd0);
    assign o_res.result_kind      = r_q[r_rd_ptr].result_kind;
    assign o_res.data_byte        = r_q[r_rd_ptr].data_byte;
    assign o_res.verdict          = r_q[r_rd_ptr].verdict;
    assign o_res.event_valid      = r_q[r_rd_ptr].event_valid;
    assign o_res.event_listen     = r_q[r_rd_ptr].event_listen;
    assign o_res.event_comm_error = r_q[r_rd_ptr].event_comm_error;
    assign o_res.event_broadcast  = r_q[r_rd_ptr].event_broadcast;
    assign o_res.message_count    = r_q[r_rd_ptr].message_count;
    assign o_res.error_count      = r_q[r_rd_ptr].error_count;

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output queue count out of range");

    // a pushed word is visible on the next cycle
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_res.valid)
        else $error("pushed word not visible");

    // a closed frame leaves the position counter at zero, hex_ok set and no held byte
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_rx.frame_end) |=> (r_pos == '0 && r_hex_ok && !r_held_valid))
        else $error("frame state not cleared after frame end");

    // every frame end produces a verdict word
    a_verdict_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_rx.frame_end) |-> push)
        else $error("frame end without verdict");

endmodule

/* tb/sv/tb_modbus_ascii_frame_receiver_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_modbus_ascii_frame_receiver_top
// Self-checking bench for the Modbus ASCII deframer. Characters are fed one
// at a time and mirrored into a behavioral deframer that predicts every
// data byte and frame verdict. Result words are compared field by field in
// order. Traffic mixes clean frames with corrupted ones under several register
// settings and several sender/receiver idle patterns. It also includes a long
// receiver hold-off and frames at and past the length limits.
// ---------------------------------------------------------------------------
module tb_modbus_ascii_frame_receiver_top;
    import mbr_pkg::*;

    // frame shapes the generator can produce
    typedef enum int {
        FR_GOOD,
        FR_BAD_LRC,
        FR_NON_HEX,
        FR_BAD_START,
        FR_BAD_TAIL,
        FR_EVEN,
        FR_SHORT,
        FR_NOISE
    } t_frame_kind;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    t_reg_idx   cfg_idx;
    logic [7:0] cfg_data;

    mbr_char_if   rx_if();
    mbr_result_if res_if();

    modbus_ascii_frame_receiver_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // register copies seen by the predictor
    logic [7:0] cfg_own;
    logic [7:0] cfg_delim;
    bit         cfg_dflt;
    bit         cfg_listen;

    // predictor frame state
    logic [9:0]  pos_q;
    bit          start_ok;
    logic [7:0]  dly0;
    logic [7:0]  dly1;
    bit          hex_ok;
    logic [3:0]  hi_nib;
    bit          phase;
    logic [7:0]  held;
    bit          held_v;
    logic [7:0]  addr_q;
    logic [7:0]  sum_q;
    logic [15:0] msg_cnt;
    logic [15:0] err_cnt;

    t_result    due_words[$];
    logic [7:0] frame_chars[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;
    int chars_sent;
    int words_checked;
    int mismatches;
    int verdict_tally[7];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #(64'd20_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // behavioral deframer
    // ------------------------------------------------------------------
    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] n);
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = 4'(c - 8'h30);
            return 1'b1;
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            n = 4'(c - 8'h41 + 8'd10);
            return 1'b1;
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            n = 4'(c - 8'h61 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_frame();
        pos_q    = '0;
        start_ok = 1'b0;
        dly0     = '0;
        dly1     = '0;
        hex_ok   = 1'b1;
        hi_nib   = '0;
        phase    = 1'b0;
        held     = '0;
        held_v   = 1'b0;
        addr_q   = '0;
        sum_q    = '0;
    endfunction

    function automatic void deframe_char(input logic [7:0] c, input bit last);
        t_result     w;
        logic [3:0]  nib;
        logic [7:0]  b;
        int unsigned flen;
        w = '0;
        if (pos_q == 0) start_ok = (c == CHAR_COLON);
        // body decode runs two characters behind the input
        if (pos_q >= 3) begin
            if (!hex_nibble(dly1, nib)) hex_ok = 1'b0;
            if (!phase) begin
                hi_nib = nib;
                phase  = 1'b1;
                // previous byte goes out only once a following byte starts,
                // so the LRC byte never leaves the block
                if (held_v && !last && start_ok && hex_ok) begin
                    w.data_byte = held;
                    due_words.push_back(w);
                end
                held_v = 1'b0;
            end else begin
                b      = {hi_nib, nib};
                sum_q  = sum_q + b;
                if (pos_q == 4) addr_q = b;
                held   = b;
                held_v = 1'b1;
                phase  = 1'b0;
            end
        end
        if (last) begin
            flen          = int'(pos_q) + 1;
            w             = '0;
            w.result_kind = 1'b1;
            if (flen < MIN_FRAME_CHARS || flen > MAX_FRAME_CHARS) begin
                w.verdict = VERDICT_LENGTH;
            end else begin
                msg_cnt        = msg_cnt + 16'd1;
                w.event_listen = cfg_listen;
                if (!start_ok || dly0 != CHAR_CR || c != cfg_delim || flen % 2 == 0) begin
                    w.verdict = VERDICT_FRAMING;
                end else if (!hex_ok) begin
                    w.verdict = VERDICT_NON_HEX;
                end else if (sum_q != 8'd0) begin
                    w.verdict          = VERDICT_LRC;
                    err_cnt            = err_cnt + 16'd1;
                    w.event_comm_error = 1'b1;
                end else if (addr_q != cfg_own && addr_q != ADDR_BROADCAST &&
                             !(cfg_dflt && addr_q == ADDR_DEFAULT)) begin
                    w.verdict = VERDICT_OTHER;
                end else if (addr_q == ADDR_BROADCAST) begin
                    w.verdict         = VERDICT_BROADCAST;
                    w.event_broadcast = 1'b1;
                end else begin
                    w.verdict = VERDICT_OK;
                end
                w.event_valid = w.event_listen | w.event_comm_error | w.event_broadcast;
            end
            w.message_count = msg_cnt;
            w.error_count   = err_cnt;
            due_words.push_back(w);
            verdict_tally[int'(w.verdict)]++;
            clear_frame();
        end else begin
            dly1 = dly0;
            dly0 = c;
            if (pos_q != POS_MAX) pos_q = pos_q + 10'd1;
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: ready pattern and checker
    // ------------------------------------------------------------------
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none actual kind %0d byte %0h verdict %0d",
                         $time, res_if.result_kind, res_if.data_byte, res_if.verdict);
            end else begin
                want = due_words.pop_front();
                check_field("result_kind", want.result_kind, res_if.result_kind);
                check_field("data_byte", want.data_byte, res_if.data_byte);
                check_field("verdict", want.verdict, res_if.verdict);
                check_field("event_valid", want.event_valid, res_if.event_valid);
                check_field("event_listen", want.event_listen, res_if.event_listen);
                check_field("event_comm_error", want.event_comm_error,
                            res_if.event_comm_error);
                check_field("event_broadcast", want.event_broadcast, res_if.event_broadcast);
                check_field("message_count", want.message_count, res_if.message_count);
                check_field("error_count", want.error_count, res_if.error_count);
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int idle_gap(input int pct);
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < pct) n++;
        return n;
    endfunction

    task automatic send_char(input logic [7:0] c, input bit last);
        int gap;
        gap = idle_gap(sender_idle_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid     <= 1'b1;
        rx_if.rx_char   <= c;
        rx_if.frame_end <= last;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        deframe_char(c, last);
        chars_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_chars[i]) send_char(frame_chars[i], i == frame_chars.size() - 1);
    endtask

    // block must be quiet before a register write; the wait runs on past the last
    // expected word to cover a character that makes no word
    task automatic wait_idle();
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OWN_ADDRESS:   cfg_own    = val;
            REG_END_DELIMITER: cfg_delim  = val;
            REG_DEFAULT_REPLY: cfg_dflt   = val[0];
            REG_LISTEN_ONLY:   cfg_listen = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] own, input logic [7:0] delim,
                              input bit dflt, input bit listen);
        wait_idle();
        write_reg(REG_OWN_ADDRESS, own);
        write_reg(REG_END_DELIMITER, delim);
        write_reg(REG_DEFAULT_REPLY, {7'd0, dflt});
        write_reg(REG_LISTEN_ONLY, {7'd0, listen});
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic bit is_hex_char(input logic [7:0] c);
        logic [3:0] n;
        return hex_nibble(c, n);
    endfunction

    // builds ':' + hex(addr, pdu, lrc) + CR + delimiter and corrupts it per kind; noise is random bytes
    task automatic make_frame(input t_frame_kind kind, input int pdu_len,
                              input logic [7:0] addr, input bit lower);
        logic [7:0] body[$];
        logic [7:0] lrc;
        logic [7:0] c;
        int         idx;
        int         cut;
        frame_chars.delete();
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 24)) frame_chars.push_back(8'($urandom));
        end else begin
            body.push_back(addr);
            lrc = addr;
            repeat (pdu_len) begin
                c = 8'($urandom);
                body.push_back(c);
                lrc = lrc + c;
            end
            lrc = 8'd0 - lrc;
            if (kind == FR_BAD_LRC) lrc = lrc ^ 8'($urandom_range(1, 255));
            body.push_back(lrc);
            frame_chars.push_back(CHAR_COLON);
            foreach (body[i]) begin
                frame_chars.push_back(hex_char(body[i][7:4], lower));
                frame_chars.push_back(hex_char(body[i][3:0], lower));
            end
            frame_chars.push_back(CHAR_CR);
            frame_chars.push_back(cfg_delim);
            case (kind)
                FR_NON_HEX: begin
                    idx = $urandom_range(1, frame_chars.size() - 3);
                    c   = 8'h30;
                    while (is_hex_char(c)) c = 8'($urandom);
                    frame_chars[idx] = c;
                end
                FR_BAD_START: begin
                    c = CHAR_COLON;
                    while (c == CHAR_COLON) c = 8'($urandom);
                    frame_chars[0] = c;
                end
                FR_BAD_TAIL: begin
                    // spoil either the CR or the delimiter
                    idx = frame_chars.size() - 1 - $urandom_range(1);
                    frame_chars[idx] = frame_chars[idx] ^ 8'($urandom_range(1, 255));
                end
                FR_EVEN: frame_chars.delete($urandom_range(1, frame_chars.size() - 3));
                FR_SHORT: begin
                    cut = $urandom_range(1, 8);
                    while (frame_chars.size() > cut) void'(frame_chars.pop_back());
                end
                default: ;
            endcase
        end
    endtask

    task automatic send_random_frame();
        int          pick;
        t_frame_kind kind;
        logic [7:0]  addr;
        int          pdu_len;
        pick = $urandom_range(99);
        if (pick < 70)      kind = FR_GOOD;
        else if (pick < 75) kind = FR_BAD_LRC;
        else if (pick < 80) kind = FR_NON_HEX;
        else if (pick < 84) kind = FR_BAD_START;
        else if (pick < 89) kind = FR_BAD_TAIL;
        else if (pick < 93) kind = FR_EVEN;
        else if (pick < 97) kind = FR_SHORT;
        else                kind = FR_NOISE;
        pick = $urandom_range(99);
        if (pick < 40)      addr = cfg_own;
        else if (pick < 55) addr = ADDR_BROADCAST;
        else if (pick < 70) addr = ADDR_DEFAULT;
        else                addr = 8'($urandom);
        pdu_len = ($urandom_range(19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        make_frame(kind, pdu_len, addr, 1'($urandom_range(1)));
        send_frame();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // shortest legal frame, lone extreme characters, lowercase broadcast,
    // an address-only frame that falls below the length floor
    task automatic test_directed_frames();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        make_frame(FR_GOOD, 1, cfg_own, 1'b0);
        send_frame();
        frame_chars = '{8'hFF};
        send_frame();
        make_frame(FR_GOOD, 1, ADDR_BROADCAST, 1'b1);
        send_frame();
        frame_chars = '{8'h00};
        send_frame();
        make_frame(FR_GOOD, 0, cfg_own, 1'b0);
        send_frame();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_chars);
        int first;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        first = chars_sent;
        while (chars_sent - first < n_chars) send_random_frame();
    endtask

    // receiver holds off while frames keep coming: the output queue fills
    // and the character input must stall without losing anything
    task automatic test_receiver_holdoff();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        hold_left = 400;
        repeat (2) begin
            make_frame(FR_GOOD, 20, cfg_own, 1'b0);
            send_frame();
        end
    endtask

    // 513 chars is the longest legal frame, 515 is past it
    task automatic test_long_frames();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        make_frame(FR_GOOD, 253, cfg_own, 1'b0);
        send_frame();
        make_frame(FR_GOOD, 254, cfg_own, 1'b1);
        send_frame();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = REG_OWN_ADDRESS;
        cfg_data           = 8'd0;
        rx_if.valid        = 1'b0;
        rx_if.rx_char      = 8'd0;
        rx_if.frame_end    = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = 0;
        chars_sent         = 0;
        words_checked      = 0;
        mismatches         = 0;
        foreach (verdict_tally[i]) verdict_tally[i] = 0;
        cfg_own    = RST_OWN_ADDRESS;
        cfg_delim  = RST_END_DELIMITER;
        cfg_dflt   = 1'b0;
        cfg_listen = 1'b0;
        msg_cnt    = '0;
        err_cnt    = '0;
        clear_frame();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();

        set_config(8'hFF, 8'h0A, 1'b1, 1'b0);
        test_random_traffic(0, 0, 140);
        set_config(8'h00, 8'hFF, 1'b0, 1'b1);
        test_random_traffic(71, 0, 140);
        set_config(ADDR_DEFAULT, 8'h00, 1'b1, 1'b1);
        test_random_traffic(0, 71, 140);
        set_config(8'($urandom_range(1, 247)), CHAR_CR, 1'b0, 1'b0);
        test_random_traffic(23, 23, 140);

        test_receiver_holdoff();

        set_config(RST_OWN_ADDRESS, RST_END_DELIMITER, 1'b0, 1'b0);
        test_long_frames();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (due_words.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected words never arrived", $time, due_words.size());
        end

        $display("Sent %0d characters, checked %0d words over 4 register settings and 4 idle mixes",
                 chars_sent, words_checked);
        $display("Verdicts ok %0d bcast %0d len %0d frame %0d hex %0d lrc %0d addr %0d",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
                 verdict_tally[4], verdict_tally[5], verdict_tally[6]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
